[hdl/dpc_pkg.sv]
// Package of types, constants and tables shared by the digit-pair decoder.
package dpc_pkg;

  localparam int INDEX_W = 51;
  localparam int COORD_W = 26;
  localparam int MODE_W  = 2;
  localparam int PAIRS_W = 5;

  localparam logic [MODE_W-1:0] MODE_STD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRI = 2'd2;

  localparam logic REG_PLOT_MODE  = 1'b0;
  localparam logic REG_PAIR_COUNT = 1'b1;

  // One item as it travels down the chain.
  typedef struct packed {
    logic               valid;
    logic [MODE_W-1:0]  mode;
    logic               big;
    logic [INDEX_W-1:0] rest;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } stage_t;

  typedef struct packed {
    logic [1:0] hi;
    logic [1:0] lo;
  } trit_pair_t;

  // Powers of nine, used both as limits and as digit weights.
  function automatic logic [INDEX_W-1:0] pow9(input logic [PAIRS_W-1:0] k);
    logic [INDEX_W-1:0] r;
    case (k)
      5'd1:    r = 51'd9;
      5'd2:    r = 51'd81;
      5'd3:    r = 51'd729;
      5'd4:    r = 51'd6561;
      5'd5:    r = 51'd59049;
      5'd6:    r = 51'd531441;
      5'd7:    r = 51'd4782969;
      5'd8:    r = 51'd43046721;
      5'd9:    r = 51'd387420489;
      5'd10:   r = 51'd3486784401;
      5'd11:   r = 51'd31381059609;
      5'd12:   r = 51'd282429536481;
      5'd13:   r = 51'd2541865828329;
      5'd14:   r = 51'd22876792454961;
      5'd15:   r = 51'd205891132094649;
      5'd16:   r = 51'd1853020188851841;
      default: r = 51'd1;
    endcase
    return r;
  endfunction

  // Splits a base-9 digit into its two base-3 digits.
  function automatic trit_pair_t split9(input logic [3:0] v);
    trit_pair_t r;
    case (v)
      4'd0:    r = '{hi: 2'd0, lo: 2'd0};
      4'd1:    r = '{hi: 2'd0, lo: 2'd1};
      4'd2:    r = '{hi: 2'd0, lo: 2'd2};
      4'd3:    r = '{hi: 2'd1, lo: 2'd0};
      4'd4:    r = '{hi: 2'd1, lo: 2'd1};
      4'd5:    r = '{hi: 2'd1, lo: 2'd2};
      4'd6:    r = '{hi: 2'd2, lo: 2'd0};
      4'd7:    r = '{hi: 2'd2, lo: 2'd1};
      4'd8:    r = '{hi: 2'd2, lo: 2'd2};
      default: r = '{hi: 2'd0, lo: 2'd0};
    endcase
    return r;
  endfunction

endpackage

[hdl/dpc_cell.sv]
// One cell of the chain: extracts the digit at a fixed position and folds it into row and column.
module dpc_cell #(
  parameter int POS = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  dpc_pkg::stage_t up,
  output logic            up_ready,
  output dpc_pkg::stage_t down,
  input  logic            down_ready
);

  localparam logic [dpc_pkg::INDEX_W-1:0] W9 = dpc_pkg::pow9(dpc_pkg::PAIRS_W'(POS));

  dpc_pkg::stage_t               held;
  dpc_pkg::stage_t               held_next;
  logic [dpc_pkg::INDEX_W-1:0]   thr [0:8];
  logic [3:0]                    v;
  dpc_pkg::trit_pair_t           tp;
  logic [1:0]                    d;
  logic                          to_row;
  logic                          to_col;

  assign up_ready = !held.valid || down_ready;
  assign down     = held;

  always_comb begin
    for (int j = 0; j <= 8; j++) begin
      thr[j] = dpc_pkg::INDEX_W'(W9 * dpc_pkg::INDEX_W'(j));
    end
    // Thresholds rise with j, so the last one passed gives the base-9 digit.
    v = 4'd0;
    for (int j = 1; j <= 8; j++) begin
      if (up.rest >= thr[j]) begin
        v = 4'(j);
      end
    end
    tp = dpc_pkg::split9(v);
    d  = up.rest[2*POS +: 2];
    if (up.mode == dpc_pkg::MODE_ALT) begin
      to_row = (d == 2'd1) || (d == 2'd2);
      to_col = (d == 2'd2) || (d == 2'd3);
    end else begin
      to_row = d[0];
      to_col = d[1];
    end

    held_next       = up;
    if (up.mode == dpc_pkg::MODE_TRI) begin
      held_next.rest = up.rest - thr[v];
      held_next.row  = {up.row[dpc_pkg::COORD_W-2:0], 1'b0} + up.row
                       + dpc_pkg::COORD_W'(tp.lo);
      held_next.col  = {up.col[dpc_pkg::COORD_W-2:0], 1'b0} + up.col
                       + dpc_pkg::COORD_W'(tp.hi);
    end else begin
      held_next.row  = {up.row[dpc_pkg::COORD_W-2:0], to_row};
      held_next.col  = {up.col[dpc_pkg::COORD_W-2:0], to_col};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (up_ready) begin
      held.valid <= up.valid;
      if (up.valid) begin
        held.mode <= held_next.mode;
        held.big  <= held_next.big;
        held.rest <= held_next.rest;
        held.row  <= held_next.row;
        held.col  <= held_next.col;
      end
    end
  end

endmodule

[hdl/digit_pair_to_plane_coordinates_core.sv]
// Top level of the digit-pair to plane coordinates decoder: configuration and the cell chain.
//
//   channel  | handshake           | payload
//   ---------+---------------------+---------------------------------------
//   in       | in_valid, in_stall  | state_index[50:0]
//   out      | out_valid, out_stall| row[25:0], column[25:0], index_too_large
//   cfg      | cfg_valid, cfg_ready| cfg_index[0:0], cfg_data[4:0]
//
// One item enters per cycle while in_stall is low; each result passes through every registered cell of the chain
// in turn, most significant digit pair first.
// Reset clears the valid bit of every cell and sets plot_mode 0, pair_count 1.
// A stalled output holds only the cells that are full behind it; empty cells keep
// filling, so the input stalls only when the whole chain is occupied.
module digit_pair_to_plane_coordinates_core #(
  parameter int MAX_PAIRS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dpc_pkg::INDEX_W-1:0]   state_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dpc_pkg::COORD_W-1:0]   row,
  output logic [dpc_pkg::COORD_W-1:0]   column,
  output logic                          index_too_large,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [dpc_pkg::PAIRS_W-1:0]   cfg_data
);

  logic [dpc_pkg::MODE_W-1:0]   plot_mode;
  logic [dpc_pkg::PAIRS_W-1:0]  pair_count;
  logic [dpc_pkg::PAIRS_W-1:0]  pairs;
  logic [dpc_pkg::INDEX_W-1:0]  limit;
  dpc_pkg::stage_t              entry;
  dpc_pkg::stage_t              link [0:MAX_PAIRS];
  logic                         rdy  [0:MAX_PAIRS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      plot_mode  <= dpc_pkg::MODE_STD;
      pair_count <= dpc_pkg::PAIRS_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dpc_pkg::REG_PLOT_MODE:  plot_mode  <= cfg_data[dpc_pkg::MODE_W-1:0];
        dpc_pkg::REG_PAIR_COUNT: pair_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pair_count == '0) begin
      pairs = dpc_pkg::PAIRS_W'(1);
    end else if (pair_count > dpc_pkg::PAIRS_W'(MAX_PAIRS)) begin
      pairs = dpc_pkg::PAIRS_W'(MAX_PAIRS);
    end else begin
      pairs = pair_count;
    end
    if (plot_mode == dpc_pkg::MODE_TRI) begin
      limit = dpc_pkg::pow9(pairs);
    end else begin
      limit = dpc_pkg::INDEX_W'(1) << {pairs, 1'b0};
    end

    entry.valid = in_valid;
    entry.mode  = plot_mode;
    entry.big   = state_index >= limit;
    entry.rest  = state_index;
    entry.row   = '0;
    entry.col   = '0;
  end

  assign link[0]         = entry;
  assign in_stall        = !rdy[0];
  assign rdy[MAX_PAIRS]  = !out_stall;

  // Cell i handles digit position MAX_PAIRS-1-i, so weights fall along the chain.
  for (genvar i = 0; i < MAX_PAIRS; i++) begin : g_cell
    dpc_cell #(
      .POS (MAX_PAIRS - 1 - i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .up         (link[i]),
      .up_ready   (rdy[i]),
      .down       (link[i+1]),
      .down_ready (rdy[i+1])
    );
  end

  assign out_valid       = link[MAX_PAIRS].valid;
  assign index_too_large = link[MAX_PAIRS].big;
  assign row             = link[MAX_PAIRS].big ? '0 : link[MAX_PAIRS].row;
  assign column          = link[MAX_PAIRS].big ? '0 : link[MAX_PAIRS].col;

endmodule

[hdl/dpc_checker.sv]
// Port-level checks for the digit-pair decoder and their binding to the top level.
module dpc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [dpc_pkg::COORD_W-1:0]  row,
  input logic [dpc_pkg::COORD_W-1:0]  column,
  input logic                         index_too_large
);

  // The chain drains into a free output, so it never refuses an item then.
  a_no_stall_when_free: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while the output was free");

  a_big_gives_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && index_too_large |-> row == '0 && column == '0)
    else $error("out-of-range item carries a nonzero coordinate");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown straight after reset");

  a_stalled_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(row) && $stable(column)
      && $stable(index_too_large))
    else $error("stalled result changed");

endmodule

bind digit_pair_to_plane_coordinates_core dpc_checker u_dpc_checker (
  .clk             (clk),
  .rst             (rst),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .row             (row),
  .column          (column),
  .index_too_large (index_too_large)
);
